// ----- hdl/mcmp_pkg.sv -----
package mcmp_pkg;

  typedef enum logic [1:0] {
    PHASE_IDLE       = 2'd0,
    PHASE_TWO_FIRST  = 2'd1,
    PHASE_TWO_SECOND = 2'd2,
    PHASE_ONE        = 2'd3
  } line_phase_e;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF     = 3'd0,
    KIND_NOTE_ON      = 3'd1,
    KIND_KEY_PRESSURE = 3'd2,
    KIND_CONTROL      = 3'd3,
    KIND_PROGRAM      = 3'd4,
    KIND_CHAN_PRESS   = 3'd5,
    KIND_BEND         = 3'd6,
    KIND_SYSTEM       = 3'd7
  } msg_kind_e;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_LISTEN_CHANNEL = 3'd0;

  localparam int unsigned TDATA_OUT_W = 64;
  localparam int unsigned TUSER_OUT_W = 5;

endpackage

// ----- hdl/midi_channel_message_parser_unit.sv -----
// Parses a stream of received MIDI bytes, one byte per slave beat, into channel voice
// messages for the channel held in the listen_channel register (byte address 0).
// Every input byte gives exactly one master beat: tuser flags a completed message with
// its kind, or a framing error, and tdata carries the data bytes, the 14-bit bend value
// and the running error count. A byte can be accepted in every cycle; its result is
// registered in the output register, and input is stalled only while that register
// holds a result that the master side has not taken. Running status is not supported.
module midi_channel_message_parser_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB-style configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcmp_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Slave side: tdata[7:0] rx_byte.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,
  // Master side: tdata[6:0] first_data, [13:7] second_data, [27:14] bend_value,
  // [59:28] error_total, [63:60] zero.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mcmp_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  // Master side: tuser[0] message_done, [3:1] message_kind, [4] byte_error.
  output logic [mcmp_pkg::TUSER_OUT_W-1:0]   m_axis_tuser
);
  import mcmp_pkg::*;

  logic [3:0]  listen_channel_q;
  line_phase_e phase_q, phase_d;
  msg_kind_e   held_status_q, held_status_d;
  logic [6:0]  held_first_q, held_first_d;
  logic [31:0] error_counter_q, error_counter_d;

  logic        out_valid_q;
  logic        done_d, err_d;
  msg_kind_e   kind_d;
  logic [6:0]  first_d, second_d;
  logic [13:0] bend_d;
  logic        done_q, err_q;
  msg_kind_e   kind_q;
  logic [6:0]  first_q, second_q;
  logic [13:0] bend_q;

  logic in_fire;
  logic is_status;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_LISTEN_CHANNEL);
  assign prdata    = (paddr == REG_LISTEN_CHANNEL) ? {28'd0, listen_channel_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_channel_q <= 4'd0;
    end else if (cfg_write) begin
      listen_channel_q <= pwdata[3:0];
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_status     = s_axis_tdata[7];

  always_comb begin
    phase_d         = phase_q;
    held_status_d   = held_status_q;
    held_first_d    = held_first_q;
    done_d          = 1'b0;
    err_d           = 1'b0;
    kind_d          = KIND_NOTE_OFF;
    first_d         = 7'd0;
    second_d        = 7'd0;
    bend_d          = 14'd0;
    unique case (phase_q)
      PHASE_IDLE: begin
        if (!is_status) begin
          err_d = 1'b1;
        end else if (s_axis_tdata[6:4] != KIND_SYSTEM &&
                     s_axis_tdata[3:0] == listen_channel_q) begin
          held_status_d = msg_kind_e'(s_axis_tdata[6:4]);
          if (s_axis_tdata[6:4] == KIND_PROGRAM || s_axis_tdata[6:4] == KIND_CHAN_PRESS) begin
            phase_d = PHASE_ONE;
          end else begin
            phase_d = PHASE_TWO_FIRST;
          end
        end
      end
      PHASE_TWO_FIRST: begin
        if (is_status) begin
          err_d   = 1'b1;
          phase_d = PHASE_IDLE;
        end else begin
          held_first_d = s_axis_tdata[6:0];
          phase_d      = PHASE_TWO_SECOND;
        end
      end
      PHASE_TWO_SECOND: begin
        phase_d = PHASE_IDLE;
        if (is_status) begin
          err_d = 1'b1;
        end else begin
          done_d   = 1'b1;
          kind_d   = held_status_q;
          first_d  = held_first_q;
          second_d = s_axis_tdata[6:0];
          if (held_status_q == KIND_BEND) begin
            bend_d = {s_axis_tdata[6:0], held_first_q};
          end
        end
      end
      PHASE_ONE: begin
        phase_d = PHASE_IDLE;
        if (is_status) begin
          err_d = 1'b1;
        end else begin
          done_d  = 1'b1;
          kind_d  = held_status_q;
          first_d = s_axis_tdata[6:0];
        end
      end
      default: begin
        phase_d = PHASE_IDLE;
      end
    endcase
    error_counter_d = err_d ? error_counter_q + 32'd1 : error_counter_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PHASE_IDLE;
      held_status_q   <= KIND_NOTE_OFF;
      held_first_q    <= 7'd0;
      error_counter_q <= 32'd0;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q         <= phase_d;
        held_status_q   <= held_status_d;
        held_first_q    <= held_first_d;
        error_counter_q <= error_counter_d;
        out_valid_q     <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      done_q   <= done_d;
      err_q    <= err_d;
      kind_q   <= kind_d;
      first_q  <= first_d;
      second_q <= second_d;
      bend_q   <= bend_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, error_counter_q, bend_q, second_q, first_q};
  assign m_axis_tuser  = {err_q, kind_q, done_q};

endmodule

// ----- hdl/mcmp_checker.sv -----
module mcmp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [mcmp_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  input logic [mcmp_pkg::TUSER_OUT_W-1:0]   m_axis_tuser
);
  import mcmp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("Stalled output beat changed.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled while the output register is empty.");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("Accepted byte gave no result beat.");

  a_done_xor_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[4]))
    else $error("Beat flags both a message and an error.");

  a_bend_only_for_bend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !(m_axis_tuser[0] && m_axis_tuser[3:1] == KIND_BEND)
      |-> m_axis_tdata[27:14] == 14'd0)
    else $error("Bend value set on a beat that is no bend message.");

endmodule

bind midi_channel_message_parser_unit mcmp_checker u_mcmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
